### sv/axypc_pkg.sv
// package: widths, payload and control types, register codes and reset values
`default_nettype none

package axypc_pkg;

    // sample and output widths
    localparam int SAMPLE_BITS = 12;
    localparam int OUT_BITS    = 15;

    // configuration field widths
    localparam int BOUND_BITS = 14;
    localparam int SHIFT_BITS = 3;
    localparam int THR_BITS   = 12;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 14;

    // derived widths for the lane datapath
    localparam int NUM_BITS   = (SAMPLE_BITS > BOUND_BITS) ? SAMPLE_BITS : BOUND_BITS;
    localparam int CLAMP_BITS = NUM_BITS + 2;
    localparam int CMP_BITS   = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
    localparam int CNT_BITS   = $clog2(OUT_BITS);

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

    // register reset values
    localparam logic [BOUND_BITS-1:0] X_LOW_RST   = BOUND_BITS'(200);
    localparam logic [BOUND_BITS-1:0] X_HIGH_RST  = BOUND_BITS'(3900);
    localparam logic [BOUND_BITS-1:0] Y_LOW_RST   = BOUND_BITS'(200);
    localparam logic [BOUND_BITS-1:0] Y_HIGH_RST  = BOUND_BITS'(3900);
    localparam logic [SHIFT_BITS-1:0] SHIFT_RST   = SHIFT_BITS'(4);
    localparam logic [THR_BITS-1:0]   THR_RST     = THR_BITS'(12);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_LOW    = 4'd0,
        CFG_X_HIGH   = 4'd1,
        CFG_Y_LOW    = 4'd2,
        CFG_Y_HIGH   = 4'd3,
        CFG_INVERT_X = 4'd4,
        CFG_INVERT_Y = 4'd5,
        CFG_SHIFT    = 4'd6,
        CFG_MOVE_THR = 4'd7
    } t_cfg_idx;

    // operation codes
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_PRESET = 1'b1
    } t_op;

    // payload of one input beat
    typedef struct packed {
        logic                   operation;
        logic [SAMPLE_BITS-1:0] sample_x;
        logic [SAMPLE_BITS-1:0] sample_y;
    } t_in_item;

    // payload of one output beat
    typedef struct packed {
        logic [OUT_BITS-1:0]    pos_x;
        logic [OUT_BITS-1:0]    pos_y;
        logic [SAMPLE_BITS-1:0] held_x;
        logic [SAMPLE_BITS-1:0] held_y;
        logic                   moved;
    } t_out_item;

    // per-lane configuration
    typedef struct packed {
        logic [BOUND_BITS-1:0] low;
        logic [BOUND_BITS-1:0] high;
        logic                  invert;
        logic [SHIFT_BITS-1:0] shift;
        logic [THR_BITS-1:0]   thr;
    } t_lane_cfg;

    // command from the controller to a lane
    typedef struct packed {
        logic start;
        logic preset;
        logic moved;
    } t_lane_cmd;

    // lane sequencer states
    typedef enum logic [1:0] {
        LS_IDLE,
        LS_PREP,
        LS_LOAD,
        LS_DIV
    } t_lane_state;

    // top-level controller states
    typedef enum logic [1:0] {
        TS_IDLE,
        TS_BUSY,
        TS_WAIT
    } t_top_state;

endpackage

`default_nettype wire

### sv/axypc_lane.sv
// one axis lane: deadband check, iir filter, clamp and bit-serial scaling divider
`default_nettype none

module axypc_lane
    import axypc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_lane_cmd              i_cmd,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire t_lane_cfg              i_cfg,
    output logic                        o_exceed,
    output logic                        o_done,
    output logic [SAMPLE_BITS-1:0]      o_held,
    output logic [OUT_BITS-1:0]         o_pos
);

    t_lane_state r_state, n_state;
    logic        r_done, n_done;
    logic [SAMPLE_BITS-1:0] r_held, n_held;
    logic [SAMPLE_BITS-1:0] r_smooth, n_smooth;
    logic [CNT_BITS-1:0]    r_cnt;
    logic [NUM_BITS-1:0]    r_num, r_den, r_rem;
    logic [OUT_BITS-1:0]    r_quo;

    logic [CMP_BITS-1:0]     abs_diff;
    logic [SAMPLE_BITS-1:0]  target;
    logic signed [SAMPLE_BITS:0] diff, biased, step;
    logic [SAMPLE_BITS:0]    bias;

    logic signed [CLAMP_BITS-1:0] lo_e, hi_e, lo_u, hi_u, v_e, vc, num_full, den_full;
    logic                         empty;

    logic [NUM_BITS+OUT_BITS-1:0] prod;
    logic [NUM_BITS:0]            rem_sh, rem_sub;
    logic                         ge;

    // deadband: raw change against the held value
    always_comb begin
        if (i_sample > r_held) begin
            abs_diff = CMP_BITS'(i_sample - r_held);
        end else begin
            abs_diff = CMP_BITS'(r_held - i_sample);
        end
        o_exceed = abs_diff > CMP_BITS'(i_cfg.thr);
    end

    // iir step, divided by a power of two with truncation toward zero
    always_comb begin
        target = i_cmd.moved ? i_sample : r_held;
        diff   = $signed({1'b0, target}) - $signed({1'b0, r_smooth});
        bias   = ~({(SAMPLE_BITS+1){1'b1}} << i_cfg.shift);
        biased = diff + $signed(bias);
        step   = (diff < 0) ? (biased >>> i_cfg.shift) : (diff >>> i_cfg.shift);
        n_held   = (i_cmd.preset || i_cmd.moved) ? i_sample : r_held;
        n_smooth = i_cmd.preset ? i_sample : (r_smooth + step[SAMPLE_BITS-1:0]);
    end

    // clamp to the bounds, falling back to the full sample range when empty
    always_comb begin
        lo_e  = CLAMP_BITS'($signed(i_cfg.low));
        hi_e  = CLAMP_BITS'($signed(i_cfg.high));
        empty = hi_e <= lo_e;
        lo_u  = empty ? '0 : lo_e;
        hi_u  = empty ? $signed({{(CLAMP_BITS-SAMPLE_BITS){1'b0}}, SAMPLE_MAX}) : hi_e;
        v_e   = $signed({{(CLAMP_BITS-SAMPLE_BITS){1'b0}}, r_smooth});
        if (v_e < lo_u) begin
            vc = lo_u;
        end else if (v_e > hi_u) begin
            vc = hi_u;
        end else begin
            vc = v_e;
        end
        num_full = vc - lo_u;
        den_full = hi_u - lo_u;
    end

    // dividend num * (2^OUT_BITS - 1) and one restoring division step
    always_comb begin
        prod    = {r_num, {OUT_BITS{1'b0}}} - {{OUT_BITS{1'b0}}, r_num};
        rem_sh  = {r_rem, r_quo[OUT_BITS-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        unique case (r_state)
            LS_IDLE: begin
                if (i_cmd.start) begin
                    n_state = LS_PREP;
                end
            end
            LS_PREP: begin
                n_state = LS_LOAD;
            end
            LS_LOAD: begin
                n_state = LS_DIV;
            end
            LS_DIV: begin
                if (r_cnt == '0) begin
                    n_state = LS_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = LS_IDLE;
            end
        endcase
    end

    // control and axis state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= LS_IDLE;
            r_done   <= 1'b0;
            r_held   <= '0;
            r_smooth <= '0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cmd.start) begin
                r_held   <= n_held;
                r_smooth <= n_smooth;
            end
            if (r_state == LS_LOAD) begin
                r_cnt <= CNT_BITS'(OUT_BITS - 1);
            end else if (r_state == LS_DIV) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        if (r_state == LS_PREP) begin
            r_num <= num_full[NUM_BITS-1:0];
            r_den <= den_full[NUM_BITS-1:0];
        end
        if (r_state == LS_LOAD) begin
            r_rem <= prod[NUM_BITS+OUT_BITS-1:OUT_BITS];
            r_quo <= prod[OUT_BITS-1:0];
        end else if (r_state == LS_DIV) begin
            r_rem <= ge ? rem_sub[NUM_BITS-1:0] : rem_sh[NUM_BITS-1:0];
            r_quo <= {r_quo[OUT_BITS-2:0], ge};
        end
    end

    // mirrored output is full scale minus value, i.e. the complement
    assign o_pos  = i_cfg.invert ? ~r_quo : r_quo;
    assign o_done = r_done;
    assign o_held = r_held;

endmodule

`default_nettype wire

### sv/axypc_merge.sv
// merging stage: gathers both lanes into the registered output beat
`default_nettype none

module axypc_merge
    import axypc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  wire logic                   i_moved,
    input  wire logic [OUT_BITS-1:0]    i_pos_x,
    input  wire logic [OUT_BITS-1:0]    i_pos_y,
    input  wire logic [SAMPLE_BITS-1:0] i_held_x,
    input  wire logic [SAMPLE_BITS-1:0] i_held_y,
    input  wire logic                   i_out_ready,
    output logic                        o_can_load,
    output logic                        o_out_valid,
    output t_out_item                   o_out_data
);

    logic      r_valid;
    t_out_item r_data, n_data;

    // combine lane results
    always_comb begin
        n_data.pos_x  = i_pos_x;
        n_data.pos_y  = i_pos_y;
        n_data.held_x = i_held_x;
        n_data.held_y = i_held_y;
        n_data.moved  = i_moved;
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
        end
    end

    assign o_can_load  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

`default_nettype wire

### sv/analog_xy_position_conditioner.sv
// top level: configuration registers, controller, two axis lanes and output stage
//
// Input channel: i_in_valid / o_in_ready with an t_in_item beat (operation,
// sample_x, sample_y). Output channel: o_out_valid / i_out_ready with a
// t_out_item beat (pos_x, pos_y, held_x, held_y, moved), one per input beat.
// Config channel: i_cfg_valid / o_cfg_ready, register index and write data;
// always ready, to be written only while no beat is in flight. Indexes
// beyond the register list are ignored.
// The X and Y lanes run side by side; each scales its axis with a restoring
// divider that produces one quotient bit per cycle.
// One input beat is processed at a time: input stays closed until the lanes
// have handed their results to the output register. A new input beat is
// taken while the last result waits in the output register.
// If the receiver stalls and the output register is still full when the
// lanes finish, the lanes hold their results and input stays blocked.
// Reset (synchronous, active low) restores register defaults and clears
// the held and filtered values and all control state.
`default_nettype none

module analog_xy_position_conditioner
    import axypc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [BOUND_BITS-1:0] r_x_low, r_x_high, r_y_low, r_y_high;
    logic                  r_invert_x, r_invert_y;
    logic [SHIFT_BITS-1:0] r_shift;
    logic [THR_BITS-1:0]   r_thr;

    t_top_state r_state, n_state;
    logic       r_moved;
    logic       accept, moved_now, load, can_load, both_done;
    logic       exceed_x, exceed_y, done_x, done_y;

    t_lane_cmd  cmd;
    t_lane_cfg  cfg_x, cfg_y;

    logic [OUT_BITS-1:0]    pos_x, pos_y;
    logic [SAMPLE_BITS-1:0] held_x, held_y;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_low    <= X_LOW_RST;
            r_x_high   <= X_HIGH_RST;
            r_y_low    <= Y_LOW_RST;
            r_y_high   <= Y_HIGH_RST;
            r_invert_x <= 1'b0;
            r_invert_y <= 1'b0;
            r_shift    <= SHIFT_RST;
            r_thr      <= THR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_X_LOW:    r_x_low    <= i_cfg_data[BOUND_BITS-1:0];
                CFG_X_HIGH:   r_x_high   <= i_cfg_data[BOUND_BITS-1:0];
                CFG_Y_LOW:    r_y_low    <= i_cfg_data[BOUND_BITS-1:0];
                CFG_Y_HIGH:   r_y_high   <= i_cfg_data[BOUND_BITS-1:0];
                CFG_INVERT_X: r_invert_x <= i_cfg_data[0];
                CFG_INVERT_Y: r_invert_y <= i_cfg_data[0];
                CFG_SHIFT:    r_shift    <= i_cfg_data[SHIFT_BITS-1:0];
                CFG_MOVE_THR: r_thr      <= i_cfg_data[THR_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // lane configuration
    always_comb begin
        cfg_x.low    = r_x_low;
        cfg_x.high   = r_x_high;
        cfg_x.invert = r_invert_x;
        cfg_x.shift  = r_shift;
        cfg_x.thr    = r_thr;
        cfg_y.low    = r_y_low;
        cfg_y.high   = r_y_high;
        cfg_y.invert = r_invert_y;
        cfg_y.shift  = r_shift;
        cfg_y.thr    = r_thr;
    end

    // accept and the shared deadband decision across both axes
    always_comb begin
        accept     = i_in_valid && o_in_ready;
        moved_now  = (i_in_data.operation == OP_SAMPLE) && (exceed_x || exceed_y);
        cmd.start  = accept;
        cmd.preset = (i_in_data.operation == OP_PRESET);
        cmd.moved  = moved_now;
        both_done  = done_x && done_y;
    end

    // controller
    always_comb begin
        n_state    = r_state;
        load       = 1'b0;
        o_in_ready = 1'b0;
        unique case (r_state)
            TS_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = TS_BUSY;
                end
            end
            TS_BUSY: begin
                if (both_done) begin
                    if (can_load) begin
                        load    = 1'b1;
                        n_state = TS_IDLE;
                    end else begin
                        n_state = TS_WAIT;
                    end
                end
            end
            TS_WAIT: begin
                if (can_load) begin
                    load    = 1'b1;
                    n_state = TS_IDLE;
                end
            end
            default: begin
                n_state = TS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TS_IDLE;
            r_moved <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_moved <= moved_now;
            end
        end
    end

    // x lane
    axypc_lane u_lane_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_sample (i_in_data.sample_x),
        .i_cfg    (cfg_x),
        .o_exceed (exceed_x),
        .o_done   (done_x),
        .o_held   (held_x),
        .o_pos    (pos_x)
    );

    // y lane
    axypc_lane u_lane_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_sample (i_in_data.sample_y),
        .i_cfg    (cfg_y),
        .o_exceed (exceed_y),
        .o_done   (done_y),
        .o_held   (held_y),
        .o_pos    (pos_y)
    );

    // output stage
    axypc_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_moved     (r_moved),
        .i_pos_x     (pos_x),
        .i_pos_y     (pos_y),
        .i_held_x    (held_x),
        .i_held_y    (held_y),
        .i_out_ready (i_out_ready),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

### sv/axypc_chk.sv
// port-level checks for the position conditioner, bound to the top level
`default_nettype none

module axypc_chk
    import axypc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // one beat at a time: input closes after an accepted beat
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accepted beat");

    // no result can appear in the cycle after acceptance
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result appeared too early");

endmodule

bind analog_xy_position_conditioner axypc_chk u_chk (.*);

`default_nettype wire

### dv/tb_analog_xy_position_conditioner.sv
`timescale 1ns / 1ps
// testbench for the xy position conditioner: directed and random beats checked by a predictor

module tb_analog_xy_position_conditioner;
    import axypc_pkg::*;

    localparam int     CLK_PERIOD      = 8;
    localparam int     RESET_CYCLES    = 9;
    localparam int     TAIL_CYCLES     = 40;
    localparam longint TIMEOUT_NS      = 5_000_000;
    localparam int     RANDOM_PHASES   = 12;
    localparam int     BEATS_PER_PHASE = 120;
    localparam int     SAMPLE_TOP      = (1 << SAMPLE_BITS) - 1;
    localparam longint POS_TOP         = (longint'(1) << OUT_BITS) - 1;
    localparam int     LAST_INDEX      = (1 << CFG_IDX_W) - 1;

    // kinds of work queued for the driver
    typedef enum {
        W_BEAT,
        W_REG,
        W_DRAIN,
        W_PACE
    } t_work_kind;

    typedef struct {
        t_work_kind            kind;
        t_in_item              beat;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_data;
        bit                    gaps_on;
    } t_work;

    // dut signals
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic                  o_cfg_ready;

    // stimulus and scoreboard state
    t_work     work_queue[$];
    t_out_item expected_positions[$];
    int        mismatches     = 0;
    int        out_beats      = 0;
    bit        in_beat_taken  = 1'b0;
    bit        cfg_beat_taken = 1'b0;
    bit        gaps_enabled   = 1'b1;
    int        gap_left       = 0;
    int        stall_left     = 0;
    int        walk_x         = 0;
    int        walk_y         = 0;

    // predictor registers and axis state
    int reg_x_low, reg_x_high, reg_y_low, reg_y_high;
    bit reg_inv_x, reg_inv_y;
    int reg_shift, reg_thr;
    int pred_held_x, pred_held_y, pred_flt_x, pred_flt_y;

    analog_xy_position_conditioner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // mismatch reporting
    task automatic flag_mismatch(string what);
        mismatches++;
        $display("mismatch: %s", what);
    endtask

    function automatic int distance(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int pin_sample(int v);
        return (v < 0) ? 0 : ((v > SAMPLE_TOP) ? SAMPLE_TOP : v);
    endfunction

    // first order filter step, quotient truncated toward zero
    function automatic int smooth_toward(int cur, int target);
        return cur + (target - cur) / (1 << reg_shift);
    endfunction

    // clamp into the bounds and map linearly onto the output range
    function automatic logic [OUT_BITS-1:0] scale_position(int v, int lo, int hi, bit inv);
        longint p;
        int     l, h, c;
        l = lo;
        h = hi;
        if (h <= l) begin
            l = 0;
            h = SAMPLE_TOP;
        end
        c = (v < l) ? l : ((v > h) ? h : v);
        p = (longint'(c) - l) * POS_TOP / (longint'(h) - l);
        if (inv) begin
            p = POS_TOP - p;
        end
        if (p < 0) begin
            p = 0;
        end
        if (p > POS_TOP) begin
            p = POS_TOP;
        end
        return OUT_BITS'(p);
    endfunction

    // one accepted sample: deadband, filter, scale
    function automatic t_out_item condition_sample(t_in_item b);
        t_out_item r;
        int        sx, sy;
        sx = int'(b.sample_x);
        sy = int'(b.sample_y);
        r.moved = 1'b0;
        if (b.operation == OP_PRESET) begin
            pred_held_x = sx;
            pred_held_y = sy;
            pred_flt_x  = sx;
            pred_flt_y  = sy;
        end else begin
            if (distance(sx, pred_held_x) > reg_thr || distance(sy, pred_held_y) > reg_thr) begin
                pred_held_x = sx;
                pred_held_y = sy;
                r.moved     = 1'b1;
            end
            pred_flt_x = smooth_toward(pred_flt_x, pred_held_x) & SAMPLE_TOP;
            pred_flt_y = smooth_toward(pred_flt_y, pred_held_y) & SAMPLE_TOP;
        end
        r.pos_x  = scale_position(pred_flt_x, reg_x_low, reg_x_high, reg_inv_x);
        r.pos_y  = scale_position(pred_flt_y, reg_y_low, reg_y_high, reg_inv_y);
        r.held_x = SAMPLE_BITS'(pred_held_x);
        r.held_y = SAMPLE_BITS'(pred_held_y);
        return r;
    endfunction

    // queue fillers
    task automatic push_beat(t_op op, int x, int y);
        t_work w;
        w.kind               = W_BEAT;
        w.beat.operation     = op;
        w.beat.sample_x      = SAMPLE_BITS'(x);
        w.beat.sample_y      = SAMPLE_BITS'(y);
        work_queue.push_back(w);
    endtask

    task automatic push_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        t_work w;
        w.kind      = W_REG;
        w.reg_index = idx;
        w.reg_data  = d;
        work_queue.push_back(w);
    endtask

    task automatic push_ctrl(t_work_kind k, bit on);
        t_work w;
        w.kind    = k;
        w.gaps_on = on;
        work_queue.push_back(w);
    endtask

    // bound pair: mostly sane, with empty, reversed and out of range pairs
    task automatic push_random_bounds(t_cfg_idx lo_idx, t_cfg_idx hi_idx);
        int lo, hi;
        case ($urandom_range(0, 9))
            0: begin
                lo = $urandom_range(0, SAMPLE_TOP);
                hi = lo;
            end
            1: begin
                hi = $urandom_range(0, 4000);
                lo = hi + int'($urandom_range(1, 95));
            end
            2: begin
                lo = -(1 << (BOUND_BITS - 1));
                hi = (1 << (BOUND_BITS - 1)) - 1;
            end
            3: begin
                lo = int'($urandom_range(0, (1 << BOUND_BITS) - 1)) - (1 << (BOUND_BITS - 1));
                hi = int'($urandom_range(0, (1 << BOUND_BITS) - 1)) - (1 << (BOUND_BITS - 1));
            end
            4: begin
                lo = $urandom_range(1000, 1900);
                hi = $urandom_range(2000, 3000);
            end
            default: begin
                lo = $urandom_range(0, 2000);
                hi = $urandom_range(2100, SAMPLE_TOP);
            end
        endcase
        push_reg(lo_idx, CFG_DATA_W'(lo));
        push_reg(hi_idx, CFG_DATA_W'(hi));
    endtask

    // full register set with junk in the unused upper bits
    task automatic push_random_settings(output int thr);
        logic [CFG_DATA_W-1:0] d;
        if ($urandom_range(0, 1)) begin
            push_reg(CFG_IDX_W'($urandom_range(CFG_MOVE_THR + 1, LAST_INDEX)),
                     CFG_DATA_W'($urandom));
        end
        push_random_bounds(CFG_X_LOW, CFG_X_HIGH);
        push_random_bounds(CFG_Y_LOW, CFG_Y_HIGH);
        push_reg(CFG_INVERT_X, CFG_DATA_W'($urandom));
        push_reg(CFG_INVERT_Y, CFG_DATA_W'($urandom));
        push_reg(CFG_SHIFT, CFG_DATA_W'($urandom));
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: thr = $urandom_range(0, 40);
            6, 7:             thr = $urandom_range(41, 1000);
            default:          thr = $urandom_range(0, SAMPLE_TOP);
        endcase
        d = CFG_DATA_W'($urandom);
        d[THR_BITS-1:0] = THR_BITS'(thr);
        push_reg(CFG_MOVE_THR, d);
    endtask

    // random walk around the held point, with jumps, extremes and presets
    task automatic push_random_beats(int count, int thr);
        int span, pick;
        span = (thr + 4 > 600) ? 600 : thr + 4;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                walk_x = $urandom_range(0, SAMPLE_TOP);
                walk_y = $urandom_range(0, SAMPLE_TOP);
                push_beat(OP_PRESET, walk_x, walk_y);
            end else begin
                if (pick < 15) begin
                    walk_x = $urandom_range(0, SAMPLE_TOP);
                    walk_y = $urandom_range(0, SAMPLE_TOP);
                end else if (pick < 20) begin
                    walk_x = $urandom_range(0, 1) ? SAMPLE_TOP : 0;
                    walk_y = $urandom_range(0, 1) ? SAMPLE_TOP : 0;
                end else begin
                    if ($urandom_range(0, 3) != 0) begin
                        walk_x = pin_sample(walk_x + int'($urandom_range(0, 2 * span)) - span);
                    end
                    if ($urandom_range(0, 3) != 0) begin
                        walk_y = pin_sample(walk_y + int'($urandom_range(0, 2 * span)) - span);
                    end
                end
                push_beat(OP_SAMPLE, walk_x, walk_y);
            end
            if ($urandom_range(0, 59) == 0) begin
                push_ctrl(W_DRAIN, 1'b0);
            end
        end
    endtask

    // driver: inputs change on the falling edge
    always @(negedge i_clk) begin : driver
        t_work head;
        if (i_rst_n) begin
            if (in_beat_taken) begin
                i_in_valid = 1'b0;
            end
            if (cfg_beat_taken) begin
                i_cfg_valid = 1'b0;
            end
            in_beat_taken  = 1'b0;
            cfg_beat_taken = 1'b0;

            // receiver ready with stall bursts
            if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
                if (gaps_enabled && $urandom_range(0, 11) == 0) begin
                    stall_left = $urandom_range(1, 17);
                end
            end

            // sender
            if (!i_in_valid && !i_cfg_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (work_queue.size() != 0) begin
                    head = work_queue[0];
                    case (head.kind)
                        W_BEAT: begin
                            i_in_data  = head.beat;
                            i_in_valid = 1'b1;
                            void'(work_queue.pop_front());
                            if (gaps_enabled && $urandom_range(0, 5) == 0) begin
                                gap_left = $urandom_range(1, 17);
                            end
                        end
                        // register writes only once the block has drained
                        W_REG: begin
                            if (expected_positions.size() == 0) begin
                                i_cfg_index = head.reg_index;
                                i_cfg_data  = head.reg_data;
                                i_cfg_valid = 1'b1;
                                void'(work_queue.pop_front());
                            end
                        end
                        W_DRAIN: begin
                            if (expected_positions.size() == 0) begin
                                void'(work_queue.pop_front());
                            end
                        end
                        default: begin
                            gaps_enabled = head.gaps_on;
                            void'(work_queue.pop_front());
                        end
                    endcase
                end
            end
        end
    end

    // monitor: handshakes sampled on the rising edge
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            reg_x_low   = int'($signed(X_LOW_RST));
            reg_x_high  = int'($signed(X_HIGH_RST));
            reg_y_low   = int'($signed(Y_LOW_RST));
            reg_y_high  = int'($signed(Y_HIGH_RST));
            reg_inv_x   = 1'b0;
            reg_inv_y   = 1'b0;
            reg_shift   = int'(SHIFT_RST);
            reg_thr     = int'(THR_RST);
            pred_held_x = 0;
            pred_held_y = 0;
            pred_flt_x  = 0;
            pred_flt_y  = 0;
        end else begin
            // result beat against the oldest expectation
            if (o_out_valid && i_out_ready) begin
                got = o_out_data;
                if (expected_positions.size() == 0) begin
                    flag_mismatch($sformatf("result beat %0d with no result pending", out_beats));
                end else begin
                    want = expected_positions.pop_front();
                    if (got.pos_x !== want.pos_x) begin
                        flag_mismatch($sformatf("beat %0d pos_x got %0d expected %0d",
                                                out_beats, got.pos_x, want.pos_x));
                    end
                    if (got.pos_y !== want.pos_y) begin
                        flag_mismatch($sformatf("beat %0d pos_y got %0d expected %0d",
                                                out_beats, got.pos_y, want.pos_y));
                    end
                    if (got.held_x !== want.held_x) begin
                        flag_mismatch($sformatf("beat %0d held_x got %0d expected %0d",
                                                out_beats, got.held_x, want.held_x));
                    end
                    if (got.held_y !== want.held_y) begin
                        flag_mismatch($sformatf("beat %0d held_y got %0d expected %0d",
                                                out_beats, got.held_y, want.held_y));
                    end
                    if (got.moved !== want.moved) begin
                        flag_mismatch($sformatf("beat %0d moved got %0d expected %0d",
                                                out_beats, got.moved, want.moved));
                    end
                end
                out_beats++;
            end

            // accepted sample
            if (i_in_valid && o_in_ready) begin
                expected_positions.push_back(condition_sample(i_in_data));
                in_beat_taken = 1'b1;
            end

            // register write, unused indexes fall through
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_X_LOW:    reg_x_low  = int'($signed(i_cfg_data[BOUND_BITS-1:0]));
                    CFG_X_HIGH:   reg_x_high = int'($signed(i_cfg_data[BOUND_BITS-1:0]));
                    CFG_Y_LOW:    reg_y_low  = int'($signed(i_cfg_data[BOUND_BITS-1:0]));
                    CFG_Y_HIGH:   reg_y_high = int'($signed(i_cfg_data[BOUND_BITS-1:0]));
                    CFG_INVERT_X: reg_inv_x  = i_cfg_data[0];
                    CFG_INVERT_Y: reg_inv_y  = i_cfg_data[0];
                    CFG_SHIFT:    reg_shift  = int'(i_cfg_data[SHIFT_BITS-1:0]);
                    CFG_MOVE_THR: reg_thr    = int'(i_cfg_data[THR_BITS-1:0]);
                    default: ;
                endcase
                cfg_beat_taken = 1'b1;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin : stimulus
        int thr;

        // reset settings: deadband edges and filter direction
        push_beat(OP_SAMPLE, 0, 0);
        push_beat(OP_SAMPLE, 12, 12);
        push_beat(OP_SAMPLE, 13, 0);
        push_beat(OP_SAMPLE, SAMPLE_TOP, SAMPLE_TOP);
        push_beat(OP_SAMPLE, SAMPLE_TOP, SAMPLE_TOP);
        push_beat(OP_PRESET, SAMPLE_TOP, SAMPLE_TOP);
        push_beat(OP_SAMPLE, 0, SAMPLE_TOP);
        push_beat(OP_PRESET, 0, 0);
        push_beat(OP_SAMPLE, 'hAAA, 'h555);
        push_beat(OP_SAMPLE, 'h555, 'hAAA);

        // widest bounds on x, empty pair on y, no smoothing, zero threshold
        push_reg(CFG_IDX_W'(LAST_INDEX), '1);
        push_reg(CFG_X_LOW, CFG_DATA_W'(-(1 << (BOUND_BITS - 1))));
        push_reg(CFG_X_HIGH, CFG_DATA_W'((1 << (BOUND_BITS - 1)) - 1));
        push_reg(CFG_Y_LOW, CFG_DATA_W'(3000));
        push_reg(CFG_Y_HIGH, CFG_DATA_W'(3000));
        push_reg(CFG_INVERT_X, CFG_DATA_W'(1));
        push_reg(CFG_INVERT_Y, ~CFG_DATA_W'(1));
        push_reg(CFG_SHIFT, ~CFG_DATA_W'(SHIFT_RST | ~SHIFT_RST));
        push_reg(CFG_MOVE_THR, CFG_DATA_W'(0));
        push_beat(OP_SAMPLE, SAMPLE_TOP, SAMPLE_TOP);
        push_beat(OP_SAMPLE, 0, 0);
        push_beat(OP_SAMPLE, 2048, 1);
        push_beat(OP_PRESET, 100, 4000);
        push_beat(OP_SAMPLE, 101, 4000);

        // reversed x pair, y bounds below the sample range, heaviest smoothing
        push_reg(CFG_X_LOW, CFG_DATA_W'(4000));
        push_reg(CFG_X_HIGH, CFG_DATA_W'(100));
        push_reg(CFG_Y_LOW, CFG_DATA_W'(-(1 << (BOUND_BITS - 1))));
        push_reg(CFG_Y_HIGH, CFG_DATA_W'(-1));
        push_reg(CFG_INVERT_Y, CFG_DATA_W'(1));
        push_reg(CFG_SHIFT, CFG_DATA_W'((1 << SHIFT_BITS) - 1));
        push_reg(CFG_MOVE_THR, CFG_DATA_W'(SAMPLE_TOP));
        push_beat(OP_SAMPLE, SAMPLE_TOP, 0);
        push_beat(OP_SAMPLE, 0, SAMPLE_TOP);
        push_beat(OP_PRESET, SAMPLE_TOP, SAMPLE_TOP);
        push_beat(OP_SAMPLE, 0, 0);
        push_beat(OP_SAMPLE, SAMPLE_TOP, SAMPLE_TOP);

        // full x range, y bounds above the sample range
        push_reg(CFG_X_LOW, CFG_DATA_W'(0));
        push_reg(CFG_X_HIGH, CFG_DATA_W'(SAMPLE_TOP));
        push_reg(CFG_Y_LOW, CFG_DATA_W'(SAMPLE_TOP + 1));
        push_reg(CFG_Y_HIGH, CFG_DATA_W'((1 << (BOUND_BITS - 1)) - 1));
        push_reg(CFG_INVERT_X, CFG_DATA_W'(0));
        push_reg(CFG_INVERT_Y, CFG_DATA_W'(0));
        push_reg(CFG_SHIFT, CFG_DATA_W'(1));
        push_reg(CFG_MOVE_THR, CFG_DATA_W'(1));
        push_beat(OP_PRESET, 0, SAMPLE_TOP);
        push_beat(OP_SAMPLE, SAMPLE_TOP, 0);
        push_beat(OP_SAMPLE, SAMPLE_TOP - 1, 1);
        push_beat(OP_SAMPLE, 2, 2);
        push_ctrl(W_DRAIN, 1'b0);

        // random phases, one quiet stretch in the middle and a quiet finish
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            push_ctrl(W_PACE, (p != 4) && (p != RANDOM_PHASES - 1));
            push_random_settings(thr);
            push_random_beats(BEATS_PER_PHASE, thr);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (work_queue.size() != 0 || i_in_valid || i_cfg_valid
               || expected_positions.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
sv/axypc_pkg.sv
sv/axypc_lane.sv
sv/axypc_merge.sv
sv/analog_xy_position_conditioner.sv
sv/axypc_chk.sv
dv/tb_analog_xy_position_conditioner.sv
